// ===== sv/cfir_pkg.sv =====
package cfir_pkg;

  // Fixed field and register widths
  localparam int TAPC_W     = 7;
  localparam int COEF_IDX_W = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [TAPC_W-1:0] TAP_COUNT_RESET = 7'd64;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAP_COUNT = 2'd0,
    REG_REAL_MODE = 2'd1
  } cfg_reg_e;

  // Input item kinds
  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_LOAD   = 1'b1
  } cmd_e;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic rot_data;
    logic rot_coef;
    logic wr_smp;
    logic wr_coef;
  } cfir_ctl_t;

endpackage

// ===== sv/complex_fir_filter.sv =====
// Flow: a sample item is written into the ring, the cell ring then rotates twice past the
// single multiplier pair at cell zero, and the rounded result is loaded into the output register.
// No new item is accepted until that result is in the output register; a coefficient load needs no run.
// Reset: 64 taps, complex mode, delay lines and coefficients cleared to zero.
// After the tap count shrinks, input stays stalled while the write slot folds back into the ring.
module complex_fir_filter import cfir_pkg::*; #(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 18,
  localparam int IN_W  = 2 * SAMPLE_BITS + COEF_IDX_W + COEF_BITS,
  localparam int IN_TD_W  = ((IN_W + 7) / 8) * 8,
  localparam int OUT_TD_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // sample_i, sample_q, coef_index, coef_value
  input  logic [IN_TD_W-1:0]    s_axis_tdata,
  // cmd
  input  logic                  s_axis_tuser,
  // Result items
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // filtered_i, filtered_q
  output logic [OUT_TD_W-1:0]   m_axis_tdata,
  // Register writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int N_W   = $clog2(MAX_TAPS + 1);
  localparam int POS_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int T_W   = N_W + 1;
  localparam int OFS_Q = SAMPLE_BITS;
  localparam int OFS_X = 2 * SAMPLE_BITS;
  localparam int OFS_C = 2 * SAMPLE_BITS + COEF_IDX_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e                        state_q, state_d;
  logic [TAPC_W-1:0]             tap_q;
  logic                          real_q;
  logic [N_W-1:0]                n;
  logic [POS_W-1:0]              ring_q, ring_d, sel_q, sel_d;
  logic [N_W-1:0]                ring_ext;
  logic                          ring_ok;
  logic [T_W-1:0]                t_q, t_d;
  logic                          t_last, mac_en;
  logic                          in_acc, is_load;
  cfir_ctl_t                     ctl;
  logic signed [SAMPLE_BITS-1:0] smp_re, smp_im, smp_im_w;
  logic [COEF_IDX_W-1:0]         coef_idx;
  logic signed [COEF_BITS-1:0]   coef_val;
  logic signed [SAMPLE_BITS-1:0] res_re, res_im;
  logic                          ov_q, ov_d;
  logic signed [SAMPLE_BITS-1:0] out_re_q, out_im_q;
  logic                          out_load;

  logic signed [SAMPLE_BITS-1:0] cell_re [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] cell_im [MAX_TAPS];
  logic signed [COEF_BITS-1:0]   cell_c  [MAX_TAPS];

  // Unpack the input item
  assign smp_re   = s_axis_tdata[SAMPLE_BITS-1:0];
  assign smp_im   = s_axis_tdata[OFS_Q +: SAMPLE_BITS];
  assign coef_idx = s_axis_tdata[OFS_X +: COEF_IDX_W];
  assign coef_val = s_axis_tdata[OFS_C +: COEF_BITS];
  assign smp_im_w = real_q ? '0 : smp_im;
  assign is_load  = (s_axis_tuser == CMD_LOAD);

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q  <= TAP_COUNT_RESET;
      real_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_TAP_COUNT: tap_q  <= cfg_data_i[TAPC_W-1:0];
        REG_REAL_MODE: real_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Clamp the tap count into the ring size
  always_comb begin
    if (tap_q == '0) begin
      n = N_W'(1);
    end else if (int'(tap_q) > MAX_TAPS) begin
      n = N_W'(MAX_TAPS);
    end else begin
      n = N_W'(tap_q);
    end
  end

  assign ring_ext = N_W'(ring_q);
  assign ring_ok  = (ring_ext < n);
  assign mac_en   = (t_q >= T_W'(sel_q)) && (t_q < T_W'(sel_q) + T_W'(n));
  assign t_last   = (t_q == (T_W'(n) << 1) - T_W'(1));

  assign s_axis_tready = (state_q == ST_IDLE) && ring_ok;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign ctl.wr_smp   = in_acc && !is_load;
  assign ctl.wr_coef  = in_acc && is_load;
  assign ctl.rot_data = (state_q == ST_RUN);
  assign ctl.rot_coef = (state_q == ST_RUN) && mac_en;

  assign out_load = (state_q == ST_DONE) && (!ov_q || m_axis_tready);

  // Sequencer: fold the write slot, align, multiply, restore, deliver
  always_comb begin
    state_d = state_q;
    ring_d  = ring_q;
    sel_d   = sel_q;
    t_d     = t_q;
    case (state_q)
      ST_IDLE: begin
        if (!ring_ok) begin
          ring_d = POS_W'(ring_ext - n);
        end else if (ctl.wr_smp) begin
          sel_d   = ring_q;
          ring_d  = (ring_q == '0) ? POS_W'(n - N_W'(1)) : ring_q - POS_W'(1);
          t_d     = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        t_d = t_q + T_W'(1);
        if (t_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ring_q  <= '0;
      sel_q   <= '0;
      t_q     <= '0;
    end else begin
      state_q <= state_d;
      ring_q  <= ring_d;
      sel_q   <= sel_d;
      t_q     <= t_d;
    end
  end

  // Ring of cells, each handing its slot to the one below
  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] nxt_re, nxt_im;
    logic signed [COEF_BITS-1:0]   nxt_c;

    if (j < MAX_TAPS - 1) begin : g_mid
      assign nxt_re = cell_re[j+1];
      assign nxt_im = cell_im[j+1];
      assign nxt_c  = cell_c[j+1];
    end else begin : g_end
      assign nxt_re = cell_re[0];
      assign nxt_im = cell_im[0];
      assign nxt_c  = cell_c[0];
    end

    cfir_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS),
      .N_W         (N_W),
      .POS_W       (POS_W),
      .CELL_IDX    (j)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .n_i         (n),
      .wr_pos_i    (ring_q),
      .coef_idx_i  (coef_idx),
      .smp_re_i    (smp_re),
      .smp_im_i    (smp_im_w),
      .coef_i      (coef_val),
      .head_re_i   (cell_re[0]),
      .head_im_i   (cell_im[0]),
      .head_coef_i (cell_c[0]),
      .next_re_i   (nxt_re),
      .next_im_i   (nxt_im),
      .next_coef_i (nxt_c),
      .re_o        (cell_re[j]),
      .im_o        (cell_im[j]),
      .coef_o      (cell_c[j])
    );
  end

  // One multiply-accumulate unit per channel at the head of the ring
  cfir_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS),
    .MAX_TAPS    (MAX_TAPS)
  ) u_mac_re (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (ctl.wr_smp),
    .en_i   (ctl.rot_coef),
    .smp_i  (cell_re[0]),
    .coef_i (cell_c[0]),
    .res_o  (res_re)
  );

  cfir_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS),
    .MAX_TAPS    (MAX_TAPS)
  ) u_mac_im (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (ctl.wr_smp),
    .en_i   (ctl.rot_coef),
    .smp_i  (cell_im[0]),
    .coef_i (cell_c[0]),
    .res_o  (res_im)
  );

  // Output register: hold the result until taken
  always_comb begin
    ov_d = ov_q;
    if (out_load) begin
      ov_d = 1'b1;
    end else if (m_axis_tready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_re_q <= res_re;
      out_im_q <= real_q ? '0 : res_im;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = OUT_TD_W'({out_im_q, out_re_q});

  // A sample item always starts a run
  a_start_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.wr_smp |=> (state_q == ST_RUN))
    else $error("sample item did not start a run");

  // The write slot stays inside the ring while an item is at work
  a_ring_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> ring_ok)
    else $error("write slot outside the ring during a run");

  // The step count advances by one each cycle of a run
  a_step_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && !t_last) |=> (state_q == ST_RUN && t_q == $past(t_q) + T_W'(1)))
    else $error("run step count broken");

endmodule

// ===== sv/cfir_cell.sv =====
module cfir_cell import cfir_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 18,
  parameter int N_W         = 7,
  parameter int POS_W       = 6,
  parameter int CELL_IDX    = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfir_ctl_t                     ctl_i,
  input  logic [N_W-1:0]                n_i,
  input  logic [POS_W-1:0]              wr_pos_i,
  input  logic [COEF_IDX_W-1:0]         coef_idx_i,
  input  logic signed [SAMPLE_BITS-1:0] smp_re_i,
  input  logic signed [SAMPLE_BITS-1:0] smp_im_i,
  input  logic signed [COEF_BITS-1:0]   coef_i,
  input  logic signed [SAMPLE_BITS-1:0] head_re_i,
  input  logic signed [SAMPLE_BITS-1:0] head_im_i,
  input  logic signed [COEF_BITS-1:0]   head_coef_i,
  input  logic signed [SAMPLE_BITS-1:0] next_re_i,
  input  logic signed [SAMPLE_BITS-1:0] next_im_i,
  input  logic signed [COEF_BITS-1:0]   next_coef_i,
  output logic signed [SAMPLE_BITS-1:0] re_o,
  output logic signed [SAMPLE_BITS-1:0] im_o,
  output logic signed [COEF_BITS-1:0]   coef_o
);

  logic signed [SAMPLE_BITS-1:0] re_q, re_d, im_q, im_d;
  logic signed [COEF_BITS-1:0]   coef_q, coef_d;
  logic                          sel_smp, sel_coef, active, last;

  // Decode this cell's place in the ring
  assign sel_smp  = (int'(wr_pos_i) == CELL_IDX);
  assign sel_coef = (int'(coef_idx_i) == CELL_IDX);
  assign active   = (CELL_IDX < int'(n_i));
  assign last     = (CELL_IDX == int'(n_i) - 1);

  // Write, rotate towards cell zero with wrap at the ring end, or hold
  always_comb begin
    re_d   = re_q;
    im_d   = im_q;
    coef_d = coef_q;
    if (ctl_i.wr_smp && sel_smp) begin
      re_d = smp_re_i;
      im_d = smp_im_i;
    end else if (ctl_i.rot_data && active) begin
      re_d = last ? head_re_i : next_re_i;
      im_d = last ? head_im_i : next_im_i;
    end
    if (ctl_i.wr_coef && sel_coef) begin
      coef_d = coef_i;
    end else if (ctl_i.rot_coef && active) begin
      coef_d = last ? head_coef_i : next_coef_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      re_q   <= '0;
      im_q   <= '0;
      coef_q <= '0;
    end else begin
      re_q   <= re_d;
      im_q   <= im_d;
      coef_q <= coef_d;
    end
  end

  assign re_o   = re_q;
  assign im_o   = im_q;
  assign coef_o = coef_q;

endmodule

// ===== sv/cfir_mac.sv =====
module cfir_mac #(
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 18,
  parameter int MAX_TAPS    = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clr_i,
  input  logic                          en_i,
  input  logic signed [SAMPLE_BITS-1:0] smp_i,
  input  logic signed [COEF_BITS-1:0]   coef_i,
  output logic signed [SAMPLE_BITS-1:0] res_o
);

  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS) + 1;
  localparam int RND_W  = ACC_W + 1;
  localparam int FRAC   = COEF_BITS - 2;
  localparam logic signed [RND_W-1:0] Half  = {{(RND_W-1){1'b0}}, 1'b1} <<< (FRAC - 1);
  localparam logic signed [RND_W-1:0] SatHi =
    ({{(RND_W-1){1'b0}}, 1'b1} <<< (SAMPLE_BITS - 1)) - 1;
  localparam logic signed [RND_W-1:0] SatLo = -SatHi - 1;

  logic signed [PROD_W-1:0] prod_q;
  logic                     pv_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [RND_W-1:0]  rnd, shr;

  // Register the product, then add it in on the following cycle
  always_ff @(posedge clk_i) begin
    prod_q <= smp_i * coef_i;
  end

  always_comb begin
    acc_d = acc_q;
    if (clr_i) begin
      acc_d = '0;
    end else if (pv_q) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      pv_q  <= en_i && !clr_i;
      acc_q <= acc_d;
    end
  end

  // Round half up, drop the fraction, saturate to the sample range
  always_comb begin
    rnd = RND_W'(acc_q) + Half;
    shr = rnd >>> FRAC;
    if (shr > SatHi) begin
      res_o = SatHi[SAMPLE_BITS-1:0];
    end else if (shr < SatLo) begin
      res_o = SatLo[SAMPLE_BITS-1:0];
    end else begin
      res_o = shr[SAMPLE_BITS-1:0];
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import cfir_pkg::*;

  localparam int MAX_TAPS      = 64;
  localparam int SMP_W         = 16;
  localparam int COEF_W        = 18;
  localparam int FRAC          = COEF_W - 2;
  localparam int IN_TD_W       = ((2 * SMP_W + COEF_IDX_W + COEF_W + 7) / 8) * 8;
  localparam int OUT_TD_W      = ((2 * SMP_W + 7) / 8) * 8;
  localparam longint SMP_MAX   = (longint'(1) <<< (SMP_W - 1)) - 1;
  localparam longint SMP_MIN   = -SMP_MAX - 1;
  localparam logic [SMP_W-1:0] SMP_HI   = SMP_W'(SMP_MAX);
  localparam logic [SMP_W-1:0] SMP_LO   = SMP_W'(SMP_MIN);
  localparam logic [COEF_W-1:0] COEF_HI = COEF_W'((1 << (COEF_W - 1)) - 1);
  localparam logic [COEF_W-1:0] COEF_LO = COEF_W'(1 << (COEF_W - 1));
  localparam logic [COEF_W-1:0] COEF_ONE  = COEF_W'(1 << FRAC);
  localparam logic [COEF_W-1:0] COEF_HALF = COEF_W'(1 << (FRAC - 1));
  localparam int SETTLE_CYCLES = 2 * MAX_TAPS + 4;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PHASE_ITEMS   = 125;
  localparam int NUM_PHASES    = 10;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_TD_W-1:0]    s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_TD_W-1:0]   m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  // Filter state as seen from the outside
  logic [TAPC_W-1:0]        tap_sel  = TAP_COUNT_RESET;
  logic                     real_sel = 1'b0;
  int                       ring_slot = 0;
  logic signed [SMP_W-1:0]  hist_i [MAX_TAPS] = '{default: '0};
  logic signed [SMP_W-1:0]  hist_q [MAX_TAPS] = '{default: '0};
  logic signed [COEF_W-1:0] coef_mem [MAX_TAPS] = '{default: '0};

  // Filtered pairs still due, {q, i}
  logic [2*SMP_W-1:0] pending_pairs [$];

  int errors    = 0;
  int cycle_cnt = 0;
  int rx_hold   = 0;
  bit idle_en   = 1'b1;

  complex_fir_filter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Stop a hung run
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // Round to nearest, ties upward, then clip to the sample range
  function automatic logic signed [SMP_W-1:0] round_sat(input longint acc);
    longint r;
    r = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    if (r > SMP_MAX) r = SMP_MAX;
    else if (r < SMP_MIN) r = SMP_MIN;
    return r[SMP_W-1:0];
  endfunction

  function automatic int taps_in_use();
    if (tap_sel == 0) return 1;
    if (tap_sel > MAX_TAPS) return MAX_TAPS;
    return int'(tap_sel);
  endfunction

  // Shift one pair into the rings and queue the filtered pair
  function automatic void filter_pair(input logic signed [SMP_W-1:0] si, sq);
    int n;
    int pos;
    int slot;
    longint acc_i;
    longint acc_q;
    logic signed [SMP_W-1:0] res_i;
    logic signed [SMP_W-1:0] res_q;
    n = taps_in_use();
    pos = ring_slot % n;
    hist_i[pos] = si;
    hist_q[pos] = real_sel ? '0 : sq;
    acc_i = 0;
    acc_q = 0;
    for (int k = 0; k < n; k++) begin
      slot = (pos + k) % n;
      acc_i += longint'(hist_i[slot]) * longint'(coef_mem[k]);
      acc_q += longint'(hist_q[slot]) * longint'(coef_mem[k]);
    end
    ring_slot = (pos == 0) ? n - 1 : pos - 1;
    res_i = round_sat(acc_i);
    res_q = real_sel ? '0 : round_sat(acc_q);
    pending_pairs.push_back({res_q, res_i});
  endfunction

  function automatic logic [SMP_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return SMP_HI;
      1:       return SMP_LO;
      2:       return '0;
      default: return SMP_W'($urandom);
    endcase
  endfunction

  // Mostly small taps so that long sums do not always clip
  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 7))
      0:       return COEF_HI;
      1:       return COEF_LO;
      2, 3:    return COEF_W'($urandom);
      default: return COEF_W'($urandom_range(0, 8191) - 4096);
    endcase
  endfunction

  // Send one item; returns at the edge where it is taken
  task automatic send_item(input cmd_e cmd, input logic [SMP_W-1:0] si, sq,
                           input logic [COEF_IDX_W-1:0] idx,
                           input logic [COEF_W-1:0] cv);
    int gap;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {cv, idx, sq, si};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    if (cmd == CMD_LOAD) coef_mem[idx] = cv;
    else filter_pair(si, sq);
  endtask

  task automatic send_sample(input logic [SMP_W-1:0] si, sq);
    send_item(CMD_SAMPLE, si, sq, COEF_IDX_W'($urandom), COEF_W'($urandom));
  endtask

  task automatic send_load(input logic [COEF_IDX_W-1:0] idx, input logic [COEF_W-1:0] cv);
    send_item(CMD_LOAD, SMP_W'($urandom), SMP_W'($urandom), idx, cv);
  endtask

  // Drop valid and wait until the filter has nothing left in flight
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == REG_TAP_COUNT) tap_sel = val[TAPC_W-1:0];
    else real_sel = val[0];
    @(posedge clk_i);
  endtask

  // Full-scale samples against full-scale taps, clipping both ways
  task automatic test_coef_extremes();
    send_load(0, COEF_HI);
    send_load(COEF_IDX_W'(MAX_TAPS - 1), COEF_LO);
    send_load(1, COEF_ONE);
    send_sample(SMP_HI, SMP_LO);
    send_sample(SMP_LO, SMP_HI);
    send_sample('0, '0);
    send_sample(SMP_HI, SMP_HI);
  endtask

  // Half-LSB ties go upward for both signs
  task automatic test_rounding();
    send_load(0, COEF_HALF);
    send_load(1, '0);
    send_load(COEF_IDX_W'(MAX_TAPS - 1), '0);
    send_sample(16'sd1, -16'sd1);
    send_sample(-16'sd1, 16'sd1);
    send_sample(16'sd3, -16'sd3);
  endtask

  // Zero tap count acts as one, oversize as full, shrink folds the write slot
  task automatic test_tap_range();
    wait_idle();
    send_load(2, COEF_ONE);
    wait_idle();
    cfg_write(REG_TAP_COUNT, 0);
    send_sample(16'sd100, -16'sd100);
    send_sample(16'sd5, 16'sd7);
    wait_idle();
    cfg_write(REG_TAP_COUNT, 127);
    send_sample(16'sd1000, -16'sd2000);
    wait_idle();
    cfg_write(REG_TAP_COUNT, 5);
    send_sample(16'sd11, 16'sd12);
    send_sample(16'sd13, 16'sd14);
    send_sample(16'sd15, 16'sd16);
  endtask

  // Real mode clears Q and feeds zeros into the Q ring
  task automatic test_real_mode();
    wait_idle();
    cfg_write(REG_REAL_MODE, 1);
    send_sample(16'sd1234, -16'sd4321);
    send_sample(SMP_HI, SMP_LO);
    wait_idle();
    cfg_write(REG_REAL_MODE, 0);
    send_sample(16'sd7, 16'sd7);
  endtask

  // Random mixes of loads and samples over a sweep of settings
  task automatic test_random_phases();
    int taps_set [NUM_PHASES] = '{1, 64, 7, 16, 3, 33, 127, 0, 12, 5};
    bit real_set [NUM_PHASES] = '{0, 1, 0, 1, 0, 0, 1, 1, 0, 0};
    int n;
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      if (p == NUM_PHASES - 1) idle_en = 1'b0;
      cfg_write(REG_TAP_COUNT, CFG_DATA_W'(taps_set[p]));
      cfg_write(REG_REAL_MODE, CFG_DATA_W'(real_set[p]));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Hold the sender once until the output side has caught up
        if (p == 3 && i == PHASE_ITEMS / 2) wait_idle();
        if ($urandom_range(0, 4) == 0) begin
          n = taps_in_use();
          if ($urandom_range(0, 1) == 0) begin
            send_load(COEF_IDX_W'($urandom_range(0, n - 1)), rand_coef());
          end else begin
            send_load(COEF_IDX_W'($urandom_range(0, MAX_TAPS - 1)), rand_coef());
          end
        end else begin
          send_sample(rand_sample(), rand_sample());
        end
      end
    end
  endtask

  // Output back-pressure in short bursts
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      rx_hold <= $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each filtered pair with the oldest one due
  always @(negedge clk_i) begin : check_pairs
    logic [2*SMP_W-1:0] want;
    logic signed [SMP_W-1:0] want_i;
    logic signed [SMP_W-1:0] want_q;
    logic signed [SMP_W-1:0] got_i;
    logic signed [SMP_W-1:0] got_q;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_i = m_axis_tdata[SMP_W-1:0];
      got_q = m_axis_tdata[2*SMP_W-1:SMP_W];
      if (pending_pairs.size() == 0) begin
        $display("%0t: unexpected item, got i %0d q %0d", $time, got_i, got_q);
        errors++;
      end else begin
        want = pending_pairs.pop_front();
        want_i = want[SMP_W-1:0];
        want_q = want[2*SMP_W-1:SMP_W];
        if (got_i !== want_i) begin
          $display("%0t: filtered_i expected %0d, got %0d", $time, want_i, got_i);
          errors++;
        end
        if (got_q !== want_q) begin
          $display("%0t: filtered_q expected %0d, got %0d", $time, want_q, got_q);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_coef_extremes();
    test_rounding();
    test_tap_range();
    test_real_mode();
    test_random_phases();
    wait_idle();
    if (pending_pairs.size() != 0) begin
      $display("%0t: %0d filtered pairs never arrived", $time, pending_pairs.size());
      errors++;
    end
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== complex_fir_filter.f =====
sv/cfir_pkg.sv
sv/cfir_cell.sv
sv/cfir_mac.sv
sv/complex_fir_filter.sv
tb/tb.sv
